[hw/rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// concurrent assertion helpers, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_IMPLIES(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
		else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
		else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, a, b)
`define ASSERT_NEXT(label, clk, rst_n, a, b)
`endif

`endif

[hw/rtl/ple_pkg.sv]
// ----------------------------------------------------------------------------
// ple_pkg
// shared types and constants of the positional list engine
// ----------------------------------------------------------------------------
package ple_pkg;

	localparam int CAPACITY_DEF = 16;
	// index math width, wide enough for the largest supported capacity
	localparam int PW = 9;

	localparam logic [2:0] MODE_INS_FRONT = 3'd0;
	localparam logic [2:0] MODE_INS_END   = 3'd1;
	localparam logic [2:0] MODE_INS_AT    = 3'd2;
	localparam logic [2:0] MODE_DEL_FRONT = 3'd3;
	localparam logic [2:0] MODE_DEL_END   = 3'd4;
	localparam logic [2:0] MODE_DEL_AT    = 3'd5;
	localparam logic [2:0] MODE_SEARCH    = 3'd6;
	localparam logic [2:0] MODE_REVERSE   = 3'd7;

	typedef struct packed {
		logic          ins;
		logic          del;
		logic [PW-1:0] pos;
		logic [PW-1:0] len;
		logic [31:0]   value;
	} ple_ctrl_t;

endpackage

[hw/rtl/ple_cell.sv]
// ----------------------------------------------------------------------------
// ple_cell
// one list slot: shifts with its neighbors on insert/delete, compares on search
// ----------------------------------------------------------------------------
module ple_cell #(
	parameter int IDX = 0
) (
	input  logic               clk,
	input  ple_pkg::ple_ctrl_t ctrl,
	input  logic [31:0]        left_data,
	input  logic [31:0]        right_data,
	output logic [31:0]        data,
	input  logic               hit_l_in,
	output logic               hit_l_out,
	input  logic               hit_r_in,
	output logic               hit_r_out,
	output logic               first_l,
	output logic               first_r
);
	import ple_pkg::*;

	logic [31:0]   data_q;
	logic [PW-1:0] idx;
	logic          match;

	assign idx = PW'(IDX);

	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			if (idx > ctrl.pos) begin
				data_q <= left_data;
			end else if (idx == ctrl.pos) begin
				data_q <= ctrl.value;
			end
		end else if (ctrl.del) begin
			if (idx >= ctrl.pos) begin
				data_q <= right_data;
			end
		end
	end

	assign data      = data_q;
	assign match     = (idx < ctrl.len) && (data_q == ctrl.value);
	assign hit_l_out = hit_l_in | match;
	assign hit_r_out = hit_r_in | match;
	assign first_l   = match & ~hit_l_in;
	assign first_r   = match & ~hit_r_in;

endmodule

[hw/rtl/positional_list_engine.sv]
// ----------------------------------------------------------------------------
// positional_list_engine
// ordered list of signed 32-bit values held in a row of shifting cells
// the result beat is registered, valid in the cycle after the request beat is taken
// throughput: one request per cycle while m_tready is high, all cells act in that cycle
// reverse flips an orientation bit, so the cells never move on reverse
// reset: arst_n clears length, orientation and output valid; cell data unreset
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module positional_list_engine #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [39:0] s_tdata,  // mode[2:0], value[34:3], position[39:35]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // ok[0], found[1], found_at[5:2], count[10:6]
);
	import ple_pkg::*;

	localparam int LW = $clog2(CAPACITY + 1);

	logic [2:0]    mode;
	logic [31:0]   value;
	logic [4:0]    position;
	logic          acc;

	logic [LW-1:0] len_q;
	logic          rev_q;
	logic          m_valid_q;
	logic          ok_q;
	logic          found_q;
	logic [3:0]    found_at_q;
	logic [4:0]    count_q;

	logic [PW-1:0] len_w;
	logic [PW-1:0] pos_w;
	logic [PW-1:0] ins_l;
	logic [PW-1:0] del_l;
	logic          is_ins;
	logic          is_del;
	logic          ins_ok;
	logic          del_ok;
	logic          op_ok;
	logic [PW-1:0] len_nx;
	logic [PW-1:0] first_idx;
	logic [PW-1:0] last_idx;
	logic [PW-1:0] where;
	logic          found;
	ple_ctrl_t     ctrl;

	logic [31:0]   cell_data [CAPACITY];
	logic [CAPACITY:0] hit_l;
	logic [CAPACITY:0] hit_r;
	logic [CAPACITY-1:0] first_l;
	logic [CAPACITY-1:0] first_r;

	assign mode     = s_tdata[2:0];
	assign value    = s_tdata[34:3];
	assign position = s_tdata[39:35];

	assign s_tready = ~m_valid_q | m_tready;
	assign acc      = s_tvalid & s_tready;

	assign len_w = PW'(len_q);
	assign pos_w = PW'(position);

	always_comb begin
		is_ins = 1'b0;
		is_del = 1'b0;
		ins_l  = pos_w;
		del_l  = pos_w;
		case (mode)
			MODE_INS_FRONT: begin is_ins = 1'b1; ins_l = '0;    end
			MODE_INS_END:   begin is_ins = 1'b1; ins_l = len_w; end
			MODE_INS_AT:    begin is_ins = 1'b1; ins_l = pos_w; end
			MODE_DEL_FRONT: begin is_del = 1'b1; del_l = '0;    end
			MODE_DEL_END:   begin is_del = 1'b1; del_l = len_w - PW'(1); end
			MODE_DEL_AT:    begin is_del = 1'b1; del_l = pos_w; end
			default:        begin is_ins = 1'b0; is_del = 1'b0; end
		endcase
	end

	assign ins_ok = is_ins && (ins_l <= len_w) && (len_w < PW'(CAPACITY));
	assign del_ok = is_del && (del_l < len_w);
	assign op_ok  = ins_ok | del_ok | (~is_ins & ~is_del);

	always_comb begin
		len_nx = len_w;
		if (ins_ok) begin
			len_nx = len_w + PW'(1);
		end else if (del_ok) begin
			len_nx = len_w - PW'(1);
		end
	end

	// logical index to physical slot under the current orientation
	always_comb begin
		ctrl.ins   = acc & ins_ok;
		ctrl.del   = acc & del_ok;
		ctrl.len   = len_w;
		ctrl.value = value;
		if (is_ins) begin
			ctrl.pos = rev_q ? (len_w - ins_l) : ins_l;
		end else begin
			ctrl.pos = rev_q ? (len_w - PW'(1) - del_l) : del_l;
		end
	end

	assign hit_l[0]        = 1'b0;
	assign hit_r[CAPACITY] = 1'b0;

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [31:0] ldat;
		logic [31:0] rdat;
		if (g == 0) begin : g_l
			assign ldat = '0;
		end else begin : g_l
			assign ldat = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_r
			assign rdat = '0;
		end else begin : g_r
			assign rdat = cell_data[g+1];
		end
		ple_cell #(
			.IDX (g)
		) u_cell (
			.clk        (clk),
			.ctrl       (ctrl),
			.left_data  (ldat),
			.right_data (rdat),
			.data       (cell_data[g]),
			.hit_l_in   (hit_l[g]),
			.hit_l_out  (hit_l[g+1]),
			.hit_r_in   (hit_r[g+1]),
			.hit_r_out  (hit_r[g]),
			.first_l    (first_l[g]),
			.first_r    (first_r[g])
		);
	end

	always_comb begin
		first_idx = '0;
		last_idx  = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			first_idx = first_idx | (first_l[i] ? PW'(i) : PW'(0));
			last_idx  = last_idx  | (first_r[i] ? PW'(i) : PW'(0));
		end
	end

	assign found = hit_l[CAPACITY];
	assign where = ~found ? PW'(0) : (rev_q ? (len_w - PW'(1) - last_idx) : first_idx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			rev_q     <= 1'b0;
			m_valid_q <= 1'b0;
		end else begin
			if (acc) begin
				len_q     <= LW'(len_nx);
				m_valid_q <= 1'b1;
				if (mode == MODE_REVERSE) begin
					rev_q <= ~rev_q;
				end
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			ok_q       <= op_ok;
			found_q    <= (mode == MODE_SEARCH) & found;
			found_at_q <= (mode == MODE_SEARCH) ? where[3:0] : 4'd0;
			count_q    <= len_nx[4:0];
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {5'd0, count_q, found_at_q, found_q, ok_q};

	`ASSERT_IMPLIES(a_len_cap, clk, arst_n, 1'b1, PW'(len_q) <= PW'(CAPACITY))
	`ASSERT_NEXT(a_ins_grows, clk, arst_n, acc && ins_ok, PW'(len_q) == $past(len_w) + PW'(1))
	`ASSERT_NEXT(a_rev_len, clk, arst_n, acc && (mode == MODE_REVERSE), $stable(len_q))
	`ASSERT_IMPLIES(a_found_ok, clk, arst_n, m_valid_q && found_q, ok_q)

endmodule

[verif/positional_list_engine_tb.sv]
// ----------------------------------------------------------------------------
// positional_list_engine_tb
// Self-checking bench for the positional list engine. A short table of
// directed requests covers empty and full lists, bad indices, extreme values,
// search at the last slot and reverse of short lists. Random requests follow:
// they steer the list length toward a moving target so the list is filled and
// drained many times. A local list model predicts every response beat, and
// each beat is compared field by field. Both stream sides idle at random.
// ----------------------------------------------------------------------------
module positional_list_engine_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ple_pkg::*;

	localparam int CAP          = CAPACITY_DEF;
	localparam int N_DIR        = 24;
	localparam int PHASE_ITEMS  = 300;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		logic [2:0]         mode;
		logic signed [31:0] value;
		logic [4:0]         position;
	} list_req_t;

	typedef struct {
		logic       ok;
		logic       found;
		logic [3:0] found_at;
		logic [4:0] count;
	} list_res_t;

	typedef struct {
		list_req_t req;
		int        reps;
		bit        typed;
		list_res_t res;
	} dir_row_t;

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;  // mode[2:0], value[34:3], position[39:35]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;        // ok[0], found[1], found_at[5:2], count[10:6]

	logic signed [31:0] list_vals [CAP];
	int                 list_len;
	int                 target_len;

	list_res_t pending_results [$];

	int src_idle_pct;
	int sink_idle_pct;
	int cycle_cnt;
	int fail_cnt;
	int sent_cnt;
	int beat_cnt;
	int search_hits;
	int reject_cnt;
	int full_cnt;
	int empty_cnt;

	logic [2:0]         ins_modes [3] = '{MODE_INS_FRONT, MODE_INS_END, MODE_INS_AT};
	logic [2:0]         del_modes [3] = '{MODE_DEL_FRONT, MODE_DEL_END, MODE_DEL_AT};
	logic signed [31:0] value_pool [8] = '{32'sh0, -32'sh1, 32'sh1, 32'sh7fffffff,
		32'sh80000000, 32'sh2a, 32'sh5a5a5a5a, 32'sha5a5a5a5};

	positional_list_engine #(
		.CAPACITY(CAP)
	) u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d beats outstanding", cycle_cnt,
				pending_results.size());
			$display("** positional_list_engine: FAILED **");
			$finish;
		end
	end

	function automatic void note_failure(string msg);
		fail_cnt++;
		if (fail_cnt <= 10)
			$display("%0t: %s", $realtime, msg);
	endfunction

	function automatic bit list_insert(int idx, logic signed [31:0] v);
		if (idx > list_len || list_len >= CAP)
			return 1'b0;
		for (int i = list_len; i > idx; i--)
			list_vals[i] = list_vals[i - 1];
		list_vals[idx] = v;
		list_len++;
		if (list_len == CAP)
			full_cnt++;
		return 1'b1;
	endfunction

	function automatic bit list_remove(int idx);
		if (idx >= list_len)
			return 1'b0;
		for (int i = idx; i + 1 < list_len; i++)
			list_vals[i] = list_vals[i + 1];
		list_len--;
		if (list_len == 0)
			empty_cnt++;
		return 1'b1;
	endfunction

	// updates the list and returns the response beat the engine should give
	function automatic list_res_t apply_list_request(list_req_t rq);
		list_res_t          rs;
		logic signed [31:0] tmp;
		int                 lo;
		int                 hi;
		rs.ok       = 1'b0;
		rs.found    = 1'b0;
		rs.found_at = '0;
		case (rq.mode)
			MODE_INS_FRONT: rs.ok = list_insert(0, rq.value);
			MODE_INS_END:   rs.ok = list_insert(list_len, rq.value);
			MODE_INS_AT:    rs.ok = list_insert(int'(rq.position), rq.value);
			MODE_DEL_FRONT: rs.ok = list_remove(0);
			MODE_DEL_END:   rs.ok = (list_len > 0) ? list_remove(list_len - 1) : 1'b0;
			MODE_DEL_AT:    rs.ok = list_remove(int'(rq.position));
			MODE_SEARCH: begin
				rs.ok = 1'b1;
				for (int i = 0; i < list_len; i++) begin
					if (!rs.found && list_vals[i] == rq.value) begin
						rs.found    = 1'b1;
						rs.found_at = 4'(i);
					end
				end
				if (rs.found)
					search_hits++;
			end
			default: begin
				rs.ok = 1'b1;
				lo = 0;
				hi = list_len - 1;
				while (lo < hi) begin
					tmp           = list_vals[lo];
					list_vals[lo] = list_vals[hi];
					list_vals[hi] = tmp;
					lo++;
					hi--;
				end
			end
		endcase
		if (!rs.ok)
			reject_cnt++;
		rs.count = 5'(list_len);
		return rs;
	endfunction

	function automatic dir_row_t dir_row(logic [2:0] mode, logic signed [31:0] value, int pos,
		int reps, bit typed, bit ok, bit found, int at, int cnt);
		dir_row_t r;
		r.req.mode     = mode;
		r.req.value    = value;
		r.req.position = 5'(pos);
		r.reps         = reps;
		r.typed        = typed;
		r.res.ok       = ok;
		r.res.found    = found;
		r.res.found_at = 4'(at);
		r.res.count    = 5'(cnt);
		return r;
	endfunction

	// length drifts toward a target that jumps between empty, full and in between
	function automatic list_req_t random_list_request();
		list_req_t rq;
		int        r;
		if ($urandom_range(39) == 0) begin
			case ($urandom_range(3))
				0:       target_len = 0;
				1:       target_len = CAP;
				default: target_len = $urandom_range(CAP);
			endcase
		end
		r = $urandom_range(99);
		if (r < 12)
			rq.mode = MODE_SEARCH;
		else if (r < 17)
			rq.mode = MODE_REVERSE;
		else if (r < 25)
			rq.mode = 3'($urandom_range(7));
		else if (list_len < target_len)
			rq.mode = ins_modes[$urandom_range(2)];
		else if (list_len > target_len)
			rq.mode = del_modes[$urandom_range(2)];
		else
			rq.mode = ($urandom_range(1) == 0) ? ins_modes[$urandom_range(2)]
				: del_modes[$urandom_range(2)];
		if (rq.mode == MODE_SEARCH && list_len > 0 && $urandom_range(9) < 6)
			rq.value = list_vals[$urandom_range(list_len - 1)];
		else if ($urandom_range(1) == 0)
			rq.value = value_pool[$urandom_range(7)];
		else
			rq.value = $urandom;
		if ($urandom_range(9) < 2)
			rq.position = 5'($urandom_range(CAP));
		else if (rq.mode == MODE_DEL_AT && list_len > 0)
			rq.position = 5'($urandom_range(list_len - 1));
		else
			rq.position = 5'($urandom_range(list_len));
		return rq;
	endfunction

	task automatic send_request(list_req_t rq, bit typed, list_res_t typed_res);
		list_res_t rs;
		while ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {rq.position, rq.value, rq.mode};
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		rs = apply_list_request(rq);
		pending_results.push_back(typed ? typed_res : rs);
		sent_cnt++;
	endtask

	always @(posedge clk) begin : resp_check
		list_res_t want;
		if (arst_n && m_tvalid && m_tready) begin
			beat_cnt++;
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected response beat %h", m_tdata));
			end else begin
				want = pending_results.pop_front();
				if (m_tdata[0] !== want.ok || m_tdata[1] !== want.found ||
					m_tdata[5:2] !== want.found_at || m_tdata[10:6] !== want.count) begin
					note_failure($sformatf(
						"beat %0d: exp ok %b found %b at %0d count %0d, got ok %b found %b at %0d count %0d",
						beat_cnt, want.ok, want.found, want.found_at, want.count,
						m_tdata[0], m_tdata[1], m_tdata[5:2], m_tdata[10:6]));
				end
			end
		end
		m_tready <= ($urandom_range(99) >= sink_idle_pct);
	end

	initial begin
		dir_row_t  dir_table [N_DIR];
		list_res_t no_res;
		int        idle_src [3] = '{9, 77, 0};
		int        idle_sink [3] = '{77, 9, 0};
		no_res = '{1'b0, 1'b0, 4'd0, 5'd0};
		dir_table = '{
			dir_row(MODE_DEL_FRONT, 32'sh0, 0, 1, 1, 0, 0, 0, 0),
			dir_row(MODE_DEL_END, 32'sh0, 0, 1, 1, 0, 0, 0, 0),
			dir_row(MODE_DEL_AT, 32'sh0, 0, 1, 1, 0, 0, 0, 0),
			dir_row(MODE_SEARCH, 32'sh0, 0, 1, 1, 1, 0, 0, 0),
			dir_row(MODE_REVERSE, 32'sh0, 0, 1, 1, 1, 0, 0, 0),
			dir_row(MODE_INS_AT, 32'sh1, 1, 1, 1, 0, 0, 0, 0),
			dir_row(MODE_INS_FRONT, 32'sh7fffffff, 0, 1, 1, 1, 0, 0, 1),
			dir_row(MODE_REVERSE, 32'sh0, 0, 1, 1, 1, 0, 0, 1),
			dir_row(MODE_INS_END, 32'sh80000000, 0, 1, 1, 1, 0, 0, 2),
			dir_row(MODE_INS_AT, -32'sh1, 2, 1, 1, 1, 0, 0, 3),
			dir_row(MODE_INS_AT, 32'sh5, 16, 1, 1, 0, 0, 0, 3),
			dir_row(MODE_SEARCH, 32'sh80000000, 0, 1, 1, 1, 1, 1, 3),
			dir_row(MODE_REVERSE, 32'sh0, 0, 1, 0, 0, 0, 0, 0),
			dir_row(MODE_INS_AT, 32'sh2a, 1, 13, 0, 0, 0, 0, 0),
			dir_row(MODE_INS_FRONT, 32'sh1, 0, 1, 1, 0, 0, 0, 16),
			dir_row(MODE_INS_END, 32'sh1, 0, 1, 1, 0, 0, 0, 16),
			dir_row(MODE_SEARCH, 32'sh7fffffff, 0, 1, 1, 1, 1, 15, 16),
			dir_row(MODE_DEL_AT, 32'sh0, 16, 1, 1, 0, 0, 0, 16),
			dir_row(MODE_SEARCH, 32'sh3039, 0, 1, 1, 1, 0, 0, 16),
			dir_row(MODE_REVERSE, 32'sh0, 0, 1, 0, 0, 0, 0, 0),
			dir_row(MODE_DEL_AT, 32'sh0, 15, 1, 0, 0, 0, 0, 0),
			dir_row(MODE_DEL_END, 32'sh0, 0, 1, 0, 0, 0, 0, 0),
			dir_row(MODE_DEL_FRONT, 32'sh0, 0, 1, 0, 0, 0, 0, 0),
			dir_row(MODE_SEARCH, 32'sh2a, 0, 1, 0, 0, 0, 0, 0)
		};
		list_len      = 0;
		target_len    = CAP / 2;
		src_idle_pct  = idle_src[0];
		sink_idle_pct = idle_sink[0];
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int r = 0; r < N_DIR; r++)
			for (int k = 0; k < dir_table[r].reps; k++)
				send_request(dir_table[r].req, dir_table[r].typed, dir_table[r].res);

		for (int ph = 0; ph < 3; ph++) begin
			src_idle_pct  = idle_src[ph];
			sink_idle_pct = idle_sink[ph];
			for (int n = 0; n < PHASE_ITEMS; n++)
				send_request(random_list_request(), 1'b0, no_res);
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d requests sent, %0d response beats checked, %0d mismatches",
			sent_cnt, beat_cnt, fail_cnt);
		$display("search hits %0d, rejected requests %0d, list filled %0d times, emptied %0d times",
			search_hits, reject_cnt, full_cnt, empty_cnt);
		if (fail_cnt == 0)
			$display("** positional_list_engine: PASSED **");
		else
			$display("** positional_list_engine: FAILED **");
		$finish;
	end

endmodule

[sim.f]
+incdir+hw/rtl
hw/rtl/ple_pkg.sv
hw/rtl/ple_cell.sv
hw/rtl/positional_list_engine.sv
verif/positional_list_engine_tb.sv
